>>> hdl/evgs_pkg.sv
// constants, types and gain factor table for the error variance gain scheduler
// no dependencies; imported by error_variance_gain_scheduler_unit
package evgs_pkg;

	localparam int TEMP_W  = 13;
	localparam int ERR_W   = 14;
	localparam int GAIN_W  = 16;
	localparam int REG_W   = 16;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// base gain times factor in tenths
	localparam int PROD_W = GAIN_W + 4;
	// floor(2^23 / 10), exact to within one for products below 2^20
	localparam int                RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] RECIP_10   = 20'd838860;
	localparam int                RECIP_SHIFT = 23;
	localparam int                QUOT_W      = PROD_W - 3;

	typedef logic [1:0] gain_set_t;
	typedef logic [3:0] tenths_t;
	typedef logic [1:0] reg_idx_t;
	typedef logic [1:0] gain_sel_t;

	localparam gain_set_t SET_DEFAULT = 2'd0;
	localparam gain_set_t SET_DAMPED  = 2'd1;
	localparam gain_set_t SET_BOOSTED = 2'd2;

	localparam reg_idx_t REG_BASE_KP  = 2'd0;
	localparam reg_idx_t REG_BASE_KI  = 2'd1;
	localparam reg_idx_t REG_BASE_KD  = 2'd2;
	localparam reg_idx_t REG_INTERVAL = 2'd3;

	localparam gain_sel_t GAIN_P = 2'd0;
	localparam gain_sel_t GAIN_I = 2'd1;
	localparam gain_sel_t GAIN_D = 2'd2;

	localparam logic [REG_W-1:0] BASE_GAIN_RST = 16'd256;
	localparam logic [REG_W-1:0] INTERVAL_RST  = 16'd10;

	// valid history window is |e| < 50 C, small error is |e| < 2 C (1/16 C units)
	localparam logic signed [ERR_W-1:0] VALID_HI = 14'sd800;
	localparam logic signed [ERR_W-1:0] VALID_LO = -14'sd800;
	localparam logic signed [ERR_W-1:0] SMALL_HI = 14'sd32;
	localparam logic signed [ERR_W-1:0] SMALL_LO = -14'sd32;

	// variance thresholds in 1/256 C^2
	localparam int VAR_HIGH_256 = 1280;
	localparam int VAR_LOW_256  = 128;

	function automatic tenths_t gain_factor(gain_set_t set, gain_sel_t which);
		tenths_t f;
		f = 4'd10;
		if (set == SET_DAMPED) begin
			unique case (which)
				GAIN_P:  f = 4'd8;
				GAIN_I:  f = 4'd5;
				default: f = 4'd12;
			endcase
		end else if (set == SET_BOOSTED) begin
			unique case (which)
				GAIN_P:  f = 4'd12;
				default: f = 4'd8;
			endcase
		end
		return f;
	endfunction

endpackage

>>> hdl/error_variance_gain_scheduler_unit.sv
// Error variance gain scheduler: one result transaction per control tick transaction.
// A tick that does not adapt goes from acceptance straight to the gain scaling steps; a tick that
// adapts first passes the history write, the walk through the error history memory at one
// read per cycle plus a final step that accumulates the last read, and the variance products
// and, when any entry is in range, the compare ahead of the gain scaling steps. The next tick
// is taken in the cycle after the result is loaded into the output register; a result not
// taken stalls the next tick only at its output load, and the input is held off until then.
// The history memory resets to all zero through per-entry valid bits, so no clearing pass.
// Depends on evgs_pkg.
module error_variance_gain_scheduler_unit
	import evgs_pkg::*;
#(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	// slave stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,   // setpoint_temp[12:0], measured_temp[25:13], zero pad
	// master stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [47:0]         m_tdata,   // kp_out[15:0], ki_out[31:16], kd_out[47:32]
	output logic [2:0]          m_tuser,   // adapted[0], gain_set[2:1]
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int N_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int SUM_W = N_W + 11;
	localparam int SQ_W  = N_W + 20;
	localparam int P1_W  = N_W + SQ_W;
	localparam int P2_W  = 2 * SUM_W;
	localparam int SP_W  = P2_W + 1;
	localparam int N2_W  = 2 * N_W;
	localparam int THR_W = N2_W + 11;
	localparam int MUL_W = PROD_W + RECIP_W;

	localparam logic [N_W-1:0]   DEPTH_N  = N_W'(HISTORY_DEPTH);
	localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(HISTORY_DEPTH - 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WRITE = 4'd1;
	localparam logic [3:0] ST_READ  = 4'd2;
	localparam logic [3:0] ST_MUL   = 4'd3;
	localparam logic [3:0] ST_CMP1  = 4'd4;
	localparam logic [3:0] ST_CMP2  = 4'd5;
	localparam logic [3:0] ST_GAIN  = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_FIX   = 4'd8;

	// configuration registers
	logic [REG_W-1:0] base_kp_q, base_ki_q, base_kd_q, interval_q;
	logic             cfg_we;

	// control state
	logic [3:0]               state_q;
	logic [REG_W-1:0]         ticks_q;
	logic [IDX_W-1:0]         pos_q;
	gain_set_t                set_q;
	logic [HISTORY_DEPTH-1:0] ent_valid_q;
	logic [N_W-1:0]           idx_q;
	logic                     pend_s1;

	// history memory
	logic signed [ERR_W-1:0] mem [HISTORY_DEPTH];
	logic signed [ERR_W-1:0] rd_data_s1;
	logic                    rd_valid_s1;
	logic                    mem_we, mem_re;

	// payload
	logic signed [ERR_W-1:0]  err_q;
	logic                     adapt_q;
	logic [N_W-1:0]           n_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]          sumsq_q;
	logic [P1_W-1:0]          p1_q;
	logic [P2_W-1:0]          p2_q;
	logic [N2_W-1:0]          n2_q;
	logic signed [SP_W-1:0]   spread_q;
	logic [THR_W-1:0]         hi_q, lo_q;
	logic [PROD_W-1:0]        x_q [3];
	logic [QUOT_W-1:0]        q0_q [3];

	logic signed [TEMP_W-1:0]  sp_temp, meas_temp;
	logic signed [ERR_W-1:0]   err_in;
	logic [REG_W-1:0]          tick_next;
	logic                      s_fire, out_free;
	logic signed [ERR_W-1:0]   e_s1;
	logic                      e_in_range;
	logic signed [2*ERR_W-1:0] e_sq;
	logic                      var_high, var_low, err_small;
	logic [GAIN_W-1:0]         base [3];
	logic [GAIN_W-1:0]         gain_res [3];

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_kp_q  <= BASE_GAIN_RST;
			base_ki_q  <= BASE_GAIN_RST;
			base_kd_q  <= BASE_GAIN_RST;
			interval_q <= INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_BASE_KP:  base_kp_q  <= pwdata[REG_W-1:0];
				REG_BASE_KI:  base_ki_q  <= pwdata[REG_W-1:0];
				REG_BASE_KD:  base_kd_q  <= pwdata[REG_W-1:0];
				REG_INTERVAL: interval_q <= pwdata[REG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_BASE_KP:  prdata = PDATA_W'(base_kp_q);
			REG_BASE_KI:  prdata = PDATA_W'(base_ki_q);
			REG_BASE_KD:  prdata = PDATA_W'(base_kd_q);
			REG_INTERVAL: prdata = PDATA_W'(interval_q);
		endcase
	end

	// input side
	assign sp_temp   = s_tdata[TEMP_W-1:0];
	assign meas_temp = s_tdata[2*TEMP_W-1:TEMP_W];
	assign err_in    = ERR_W'(sp_temp) - ERR_W'(meas_temp);
	assign tick_next = ticks_q + REG_W'(1);
	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid & s_tready;
	assign out_free  = !m_tvalid || m_tready;

	assign mem_we = (state_q == ST_WRITE);
	assign mem_re = (state_q == ST_READ) && (idx_q < DEPTH_N);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ticks_q     <= '0;
			pos_q       <= '0;
			set_q       <= SET_DEFAULT;
			ent_valid_q <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
		end else begin
			pend_s1 <= mem_re;
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (tick_next >= interval_q) begin
							ticks_q <= '0;
							state_q <= ST_WRITE;
						end else begin
							ticks_q <= tick_next;
							state_q <= ST_GAIN;
						end
					end
				end
				ST_WRITE: begin
					ent_valid_q[pos_q] <= 1'b1;
					pos_q   <= (pos_q == LAST_POS) ? '0 : pos_q + IDX_W'(1);
					idx_q   <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					if (idx_q < DEPTH_N) begin
						idx_q <= idx_q + N_W'(1);
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= (n_q == '0) ? ST_GAIN : ST_CMP1;
				end
				ST_CMP1: begin
					state_q <= ST_CMP2;
				end
				ST_CMP2: begin
					priority if (var_high) begin
						set_q <= SET_DAMPED;
					end else if (var_low && err_small) begin
						set_q <= SET_BOOSTED;
					end else begin
						set_q <= SET_DEFAULT;
					end
					state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// history memory, one write or one read per cycle, write always precedes the walk
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[pos_q] <= err_q;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else if (mem_re) begin
			rd_valid_s1 <= ent_valid_q[idx_q[IDX_W-1:0]];
		end
	end

	// accumulate over the walk
	assign e_s1       = rd_valid_s1 ? rd_data_s1 : '0;
	assign e_in_range = (e_s1 > VALID_LO) && (e_s1 < VALID_HI);
	assign e_sq       = (2*ERR_W)'(e_s1) * (2*ERR_W)'(e_s1);

	assign var_high  = spread_q > $signed(SP_W'(hi_q));
	assign var_low   = spread_q < $signed(SP_W'(lo_q));
	assign err_small = (err_q > SMALL_LO) && (err_q < SMALL_HI);

	assign base[0] = base_kp_q;
	assign base[1] = base_ki_q;
	assign base[2] = base_kd_q;

	always_ff @(posedge clk) begin
		if (s_fire) begin
			err_q   <= err_in;
			adapt_q <= (tick_next >= interval_q);
		end
		if (state_q == ST_WRITE) begin
			n_q     <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (pend_s1 && e_in_range) begin
			n_q     <= n_q + N_W'(1);
			sum_q   <= sum_q + SUM_W'(e_s1);
			sumsq_q <= sumsq_q + SQ_W'(e_sq[19:0]);
		end
		if (state_q == ST_MUL) begin
			p1_q <= P1_W'(n_q) * P1_W'(sumsq_q);
			p2_q <= P2_W'(sum_q) * P2_W'(sum_q);
			n2_q <= N2_W'(n_q) * N2_W'(n_q);
		end
		if (state_q == ST_CMP1) begin
			spread_q <= $signed(SP_W'(p1_q)) - $signed(SP_W'(p2_q));
			hi_q     <= THR_W'(n2_q) * THR_W'(VAR_HIGH_256);
			lo_q     <= THR_W'(n2_q) * THR_W'(VAR_LOW_256);
		end
		for (int i = 0; i < 3; i++) begin
			if (state_q == ST_GAIN) begin
				x_q[i] <= PROD_W'(base[i]) * PROD_W'(gain_factor(set_q, gain_sel_t'(i)));
			end
			if (state_q == ST_DIV) begin
				q0_q[i] <= QUOT_W'((MUL_W'(x_q[i]) * MUL_W'(RECIP_10)) >> RECIP_SHIFT);
			end
		end
	end

	// divide by ten correction and saturation
	always_comb begin
		logic [PROD_W-1:0] rem;
		logic [QUOT_W-1:0] quot;
		for (int i = 0; i < 3; i++) begin
			rem  = x_q[i] - PROD_W'(q0_q[i]) * PROD_W'(10);
			quot = (rem >= PROD_W'(10)) ? q0_q[i] + QUOT_W'(1) : q0_q[i];
			gain_res[i] = (quot > QUOT_W'({GAIN_W{1'b1}})) ? {GAIN_W{1'b1}} : quot[GAIN_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if ((state_q == ST_FIX) && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIX) && out_free) begin
			m_tdata <= {gain_res[2], gain_res[1], gain_res[0]};
			m_tuser <= {set_q, adapt_q};
		end
	end

`ifndef SYNTH
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("ring write position out of range");

	a_ticks_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (ticks_q == '0))
		else $error("tick count not cleared on adaptation");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP1) |-> ((n_q != '0) && (n_q <= DEPTH_N)))
		else $error("valid entry count out of range at compare");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX) && !out_free |=> (state_q == ST_FIX))
		else $error("result dropped while output busy");
`endif

endmodule
